// ----- rtl/ndc_pkg.sv -----
// shared constants, types and helpers for the normalized id duplicate check
package ndc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int KEY_CHARS     = 20;

  localparam int CHAR_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  localparam int LEN_W     = $clog2(KEY_CHARS + 1);
  localparam int KB_AW     = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TBL_DEPTH = TABLE_ENTRIES * KEY_CHARS;
  localparam int BASE_W    = $clog2(TBL_DEPTH + 1);
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED = 2'd0,
    STATUS_DUP    = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CHECK,
    SEQ_ENTRY,
    SEQ_LEN_CMP,
    SEQ_CHR_RD,
    SEQ_CHR_CMP,
    SEQ_STORE,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic push;
    logic clear;
  } kb_ctrl_t;

  typedef struct packed {
    logic    busy;
    logic    res_valid;
    status_e status;
  } seq_stat_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h09) && (c <= 8'h0d)) || (c == 8'h20);
  endfunction

  function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if ((c >= 8'h41) && (c <= 8'h5a)) r = c + 8'h20;
    return r;
  endfunction

endpackage

// ----- rtl/ndc_key_builder.sv -----
// key builder: normalises raw bytes into the key buffer
module ndc_key_builder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ndc_pkg::kb_ctrl_t           ctrl_i,
  input  logic [ndc_pkg::CHAR_W-1:0]  char_i,
  input  logic [ndc_pkg::KB_AW-1:0]   rd_idx_i,
  output logic [ndc_pkg::CHAR_W-1:0]  rd_data_o,
  output logic [ndc_pkg::LEN_W-1:0]   key_len_o
);
  import ndc_pkg::*;

  logic [CHAR_W-1:0] buf_q [KEY_CHARS];
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  raw_q, raw_d;
  logic              stopped_q, stopped_d;
  logic [CHAR_W-1:0] norm;
  logic              take;
  logic              keep;

  always_comb begin
    norm      = to_lower(char_i);
    take      = ctrl_i.push && !stopped_q && (raw_q < LEN_W'(KEY_CHARS));
    keep      = take && (char_i != '0) && !is_blank(norm) && (len_q < LEN_W'(KEY_CHARS));
    raw_d     = raw_q;
    len_d     = len_q;
    stopped_d = stopped_q;
    if (ctrl_i.clear) begin
      raw_d     = '0;
      len_d     = '0;
      stopped_d = 1'b0;
    end else if (take) begin
      raw_d = raw_q + LEN_W'(1);
      if (char_i == '0) stopped_d = 1'b1;
      if (keep) len_d = len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q     <= '0;
      len_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      raw_q     <= raw_d;
      len_q     <= len_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) buf_q[len_q[KB_AW-1:0]] <= norm;
  end

  assign rd_data_o = buf_q[rd_idx_i];
  assign key_len_o = len_q;

endmodule

// ----- rtl/ndc_table.sv -----
// key table with its search and append sequencer
module ndc_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        take_i,
  input  logic [ndc_pkg::LEN_W-1:0]   key_len_i,
  input  logic [ndc_pkg::CHAR_W-1:0]  key_data_i,
  output logic [ndc_pkg::KB_AW-1:0]   key_idx_o,
  output ndc_pkg::seq_stat_t          stat_o,
  output logic [ndc_pkg::CNT_W-1:0]   count_o
);
  import ndc_pkg::*;

  logic [CHAR_W-1:0] key_table [TBL_DEPTH];
  logic [LEN_W-1:0]  entry_lengths [TABLE_ENTRIES];

  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  e_q, e_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [KB_AW-1:0]  k_q, k_d;
  status_e           status_q, status_d;
  logic [LEN_W-1:0]  len_rd_q;
  logic [CHAR_W-1:0] chr_rd_q;

  logic              last_k, at_end, full;
  logic              rd_len, rd_chr, wr_chr, wr_len;
  logic [TBL_AW-1:0] tbl_addr;

  assign last_k   = (LEN_W'(k_q) + LEN_W'(1)) == key_len_i;
  assign at_end   = (e_q == count_q);
  assign full     = (count_q == CNT_W'(TABLE_ENTRIES));
  assign tbl_addr = TBL_AW'(base_q + BASE_W'(k_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE:    if (start_i) state_d = SEQ_CHECK;
      SEQ_CHECK:   state_d = (key_len_i == '0) ? SEQ_DONE : SEQ_ENTRY;
      SEQ_ENTRY: begin
        if (at_end) state_d = full ? SEQ_DONE : SEQ_STORE;
        else        state_d = SEQ_LEN_CMP;
      end
      SEQ_LEN_CMP: state_d = (len_rd_q == key_len_i) ? SEQ_CHR_RD : SEQ_ENTRY;
      SEQ_CHR_RD:  state_d = SEQ_CHR_CMP;
      SEQ_CHR_CMP: begin
        if (chr_rd_q != key_data_i) state_d = SEQ_ENTRY;
        else if (last_k)            state_d = SEQ_DONE;
        else                        state_d = SEQ_CHR_RD;
      end
      SEQ_STORE:   if (last_k) state_d = SEQ_DONE;
      SEQ_DONE:    if (take_i) state_d = SEQ_IDLE;
      default:     state_d = SEQ_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    e_d      = e_q;
    base_d   = base_q;
    k_d      = k_q;
    count_d  = count_q;
    status_d = status_q;
    rd_len   = 1'b0;
    rd_chr   = 1'b0;
    wr_chr   = 1'b0;
    wr_len   = 1'b0;
    unique case (state_q)
      SEQ_CHECK: begin
        e_d    = '0;
        base_d = '0;
        if (key_len_i == '0) status_d = STATUS_EMPTY;
      end
      SEQ_ENTRY: begin
        if (at_end) begin
          k_d = '0;
          if (full) status_d = STATUS_FULL;
        end else begin
          rd_len = 1'b1;
        end
      end
      SEQ_LEN_CMP: begin
        if (len_rd_q == key_len_i) begin
          k_d = '0;
        end else begin
          e_d    = e_q + CNT_W'(1);
          base_d = base_q + BASE_W'(KEY_CHARS);
        end
      end
      SEQ_CHR_RD: rd_chr = 1'b1;
      SEQ_CHR_CMP: begin
        if (chr_rd_q != key_data_i) begin
          e_d    = e_q + CNT_W'(1);
          base_d = base_q + BASE_W'(KEY_CHARS);
        end else if (last_k) begin
          status_d = STATUS_DUP;
        end else begin
          k_d = k_q + KB_AW'(1);
        end
      end
      SEQ_STORE: begin
        wr_chr = 1'b1;
        if (last_k) begin
          wr_len   = 1'b1;
          count_d  = count_q + CNT_W'(1);
          status_d = STATUS_STORED;
        end else begin
          k_d = k_q + KB_AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    base_q   <= base_d;
    k_q      <= k_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_chr) key_table[tbl_addr] <= key_data_i;
    if (rd_chr) chr_rd_q <= key_table[tbl_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_len) entry_lengths[count_q[IDX_W-1:0]] <= key_len_i;
    if (rd_len) len_rd_q <= entry_lengths[e_q[IDX_W-1:0]];
  end

  assign key_idx_o        = k_q;
  assign count_o          = count_q;
  assign stat_o.busy      = (state_q != SEQ_IDLE);
  assign stat_o.res_valid = (state_q == SEQ_DONE);
  assign stat_o.status    = status_q;

endmodule

// ----- rtl/normalized_id_duplicate_check.sv -----
// top level: byte-serial identifier intake, table lookup and result register
//
// identifiers arrive one byte per word, the final byte flagged by last_char_i.
// only the first KEY_CHARS (20) raw bytes are looked at and a zero byte ends
// the scan; letters are folded to lower case and whitespace (tab to carriage
// return, space) is dropped. a byte that is not the final one gives no result.
// on the final byte the block drops in_ready_o and one shared byte comparator
// walks the table: for each stored key it reads and compares the length and,
// on a match, reads and compares the key one character at a time. if no key
// matches and the table is not full, the new key is written one byte at a time
// (table memory has a single port). the result then moves to the output
// register, which can hold a word while the next identifier's bytes are
// already being taken. the result word gives accepted_o, status_o (stored,
// duplicate, empty, full) and the number of keys held afterwards. the table
// is never cleared: only entries below the fill count are ever read, so reset
// needs no clearing pass.
module normalized_id_duplicate_check (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ndc_pkg::CHAR_W-1:0]           char_in_i,
  input  logic                                 last_char_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 accepted_o,
  output logic [ndc_pkg::STATUS_W-1:0]         status_o,
  output logic [ndc_pkg::COUNT_OUT_W-1:0]      stored_count_o
);
  import ndc_pkg::*;

  kb_ctrl_t          kb_ctrl;
  seq_stat_t         seq_stat;
  logic [LEN_W-1:0]  key_len;
  logic [KB_AW-1:0]  key_idx;
  logic [CHAR_W-1:0] key_data;
  logic [CNT_W-1:0]  count;

  logic in_acc;
  logic take;

  logic                   out_valid_q, out_valid_d;
  logic                   accepted_q;
  status_e                status_q;
  logic [COUNT_OUT_W-1:0] count_q;

  // input words are taken whenever the lookup sequencer is idle
  assign in_ready_o = !seq_stat.busy;
  assign in_acc     = in_valid_i && in_ready_o;

  // result moves to the output register once that is free or being emptied
  assign take = seq_stat.res_valid && (!out_valid_q || out_ready_i);

  assign kb_ctrl.push  = in_acc;
  assign kb_ctrl.clear = take;

  ndc_key_builder u_key (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (kb_ctrl),
    .char_i    (char_in_i),
    .rd_idx_i  (key_idx),
    .rd_data_o (key_data),
    .key_len_o (key_len)
  );

  ndc_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && last_char_i),
    .take_i     (take),
    .key_len_i  (key_len),
    .key_data_i (key_data),
    .key_idx_o  (key_idx),
    .stat_o     (seq_stat),
    .count_o    (count)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (take)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      accepted_q <= (seq_stat.status == STATUS_STORED);
      status_q   <= seq_stat.status;
      count_q    <= COUNT_OUT_W'(count);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign status_o       = status_q;
  assign stored_count_o = count_q;

endmodule

// ----- rtl/ndc_checker.sv -----
// port-level checks for the normalized id duplicate check, bound to the top level
module ndc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic [ndc_pkg::CHAR_W-1:0]           char_in_i,
  input logic                                 last_char_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 accepted_o,
  input logic [ndc_pkg::STATUS_W-1:0]         status_o,
  input logic [ndc_pkg::COUNT_OUT_W-1:0]      stored_count_o
);
  import ndc_pkg::*;

  // a pending result word is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(stored_count_o))
    else $error("result word changed while stalled");

  // accepted flag agrees with the stored status
  a_acc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (status_o == STATUS_STORED)))
    else $error("accepted flag disagrees with status");

  // a stored key leaves the table non-empty
  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> (stored_count_o != '0))
    else $error("key stored but count is zero");

  // the final byte starts a table walk, so intake pauses
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_char_i |=> !in_ready_o)
    else $error("intake still open after final byte");

endmodule

bind normalized_id_duplicate_check ndc_checker u_ndc_checker (.*);

// ----- dv/ndc_lookup_watch.sv -----
// channel monitor with identifier table prediction and result comparison
module ndc_lookup_watch
  import ndc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [CHAR_W-1:0]      char_in_i,
  input  logic                   last_char_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   accepted_i,
  input  logic [STATUS_W-1:0]    status_i,
  input  logic [COUNT_OUT_W-1:0] stored_count_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     stored_o,
  output int                     dup_o,
  output int                     empty_o,
  output int                     full_o
);

  typedef struct packed {
    logic                   accepted;
    status_e                status;
    logic [COUNT_OUT_W-1:0] count;
  } verdict_t;

  verdict_t verdicts_due[$];

  // key under construction, zero padded past its length
  logic [8*KEY_CHARS-1:0] cur_key = '0;
  int unsigned            cur_len = 0;
  int unsigned            raw_seen = 0;
  bit                     scan_halted = 1'b0;

  logic [8*KEY_CHARS-1:0] held_keys [TABLE_ENTRIES];
  int unsigned            held_lens [TABLE_ENTRIES];
  int unsigned            held_total = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    stored_o     = 0;
    dup_o        = 0;
    empty_o      = 0;
    full_o       = 0;
  end

  task automatic predict_lookup(input logic [7:0] raw, input logic fin);
    logic [7:0] c;
    verdict_t   want;
    bit         hit;
    c = raw;
    if (!scan_halted && raw_seen < KEY_CHARS) begin
      raw_seen++;
      if (c == 8'h00) begin
        scan_halted = 1'b1;
      end else begin
        if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
        if (!((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) && cur_len < KEY_CHARS) begin
          cur_key[8*cur_len +: 8] = c;
          cur_len++;
        end
      end
    end
    if (fin) begin
      hit = 1'b0;
      want.accepted = 1'b0;
      if (cur_len == 0) begin
        want.status = STATUS_EMPTY;
      end else begin
        for (int e = 0; e < held_total && !hit; e++)
          if (held_lens[e] == cur_len && held_keys[e] == cur_key) hit = 1'b1;
        if (hit) begin
          want.status = STATUS_DUP;
        end else if (held_total >= TABLE_ENTRIES) begin
          want.status = STATUS_FULL;
        end else begin
          held_keys[held_total] = cur_key;
          held_lens[held_total] = cur_len;
          held_total++;
          want.status   = STATUS_STORED;
          want.accepted = 1'b1;
        end
      end
      want.count = COUNT_OUT_W'(held_total);
      verdicts_due.push_back(want);
      cur_key     = '0;
      cur_len     = 0;
      raw_seen    = 0;
      scan_halted = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (rst_ni) begin
      // result side first: a word leaving now belongs to an older identifier
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("result word with no lookup outstanding: accepted %0d status %0d count %0d",
                 accepted_i, status_i, stored_count_i);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (accepted_i !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, accepted_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (stored_count_i !== want.count) begin
            $error("stored_count: expected %0d, actual %0d", want.count, stored_count_i);
            fail_count_o++;
          end
          case (want.status)
            STATUS_STORED: stored_o++;
            STATUS_DUP:    dup_o++;
            STATUS_EMPTY:  empty_o++;
            STATUS_FULL:   full_o++;
            default: ;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) predict_lookup(char_in_i, last_char_i);
      pending_o = verdicts_due.size();
    end
  end

endmodule

// ----- dv/normalized_id_duplicate_check_tb.sv -----
// stimulus, handshake pacing and verdict for the normalized id duplicate check
module normalized_id_duplicate_check_tb;

  localparam int POOL_SLOTS  = 32;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_WAIT  = 1200;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [ndc_pkg::CHAR_W-1:0]        char_in_i;
  logic                              last_char_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic                              accepted_o;
  logic [ndc_pkg::STATUS_W-1:0]      status_o;
  logic [ndc_pkg::COUNT_OUT_W-1:0]   stored_count_o;

  int fails, pending, n_stored, n_dup, n_empty, n_full;

  // pacing knobs, set by the stimulus per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fresh_pct     = 80;
  bit hold_pending  = 1'b0;
  int hold_left     = 0;
  int words_sent    = 0;

  // raw byte strings already sent, replayed later to provoke duplicates
  logic [7:0] pool_bytes [POOL_SLOTS][32];
  int         pool_len [POOL_SLOTS];
  int         pool_used = 0;
  logic [7:0] word_buf [32];

  normalized_id_duplicate_check dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .status_o       (status_o),
    .stored_count_o (stored_count_o)
  );

  ndc_lookup_watch watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .char_in_i      (char_in_i),
    .last_char_i    (last_char_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_i     (accepted_o),
    .status_i       (status_o),
    .stored_count_i (stored_count_o),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .stored_o       (n_stored),
    .dup_o          (n_dup),
    .empty_o        (n_empty),
    .full_o         (n_full)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs; far beyond any lookup-bound run
  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, or a long hold-off counted here so that the
  // output register stays full and the block has to push back on its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one word onto the input channel: optional idle gap, then hold until taken
  task automatic put_word(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_in_i   <= c;
    last_char_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'(9 + r);
  endfunction

  // mostly letters of either case and digits, some blanks, a rare zero,
  // and the odd byte from anywhere (high half included)
  function automatic logic [7:0] any_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'(8'h41 + $urandom_range(25));
    else if (r < 55) return 8'(8'h61 + $urandom_range(25));
    else if (r < 65) return 8'(8'h30 + $urandom_range(9));
    else if (r < 73) return blank_char();
    else if (r < 76) return 8'h00;
    else return 8'($urandom_range(255));
  endfunction

  // short keys dominate so the table fills; a few run past the key limit
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 74) return $urandom_range(2, 1);
    else if (r < 96) return $urandom_range(10, 3);
    else return $urandom_range(28, 18);
  endfunction

  // one whole identifier: fresh, replayed with case and blank changes,
  // nothing left after normalising, or plain byte noise
  task automatic send_ident();
    int         r, n, slot, pos;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < fresh_pct || pool_used == 0) begin
      n = pick_len();
      for (int k = 0; k < n; k++) word_buf[k] = any_char();
      if (pool_used < POOL_SLOTS) begin
        slot = pool_used;
        pool_used++;
      end else begin
        slot = $urandom_range(POOL_SLOTS - 1);
      end
      for (int k = 0; k < n; k++) pool_bytes[slot][k] = word_buf[k];
      pool_len[slot] = n;
    end else if (r < fresh_pct + 8) begin
      n = $urandom_range(5, 1);
      for (int k = 0; k < n; k++) word_buf[k] = blank_char();
      if ($urandom_range(1) == 1) begin
        // zero up front, whatever follows is ignored
        word_buf[0] = 8'h00;
        for (int k = 1; k < n; k++) word_buf[k] = 8'($urandom_range(255));
      end
    end else if (r < fresh_pct + 14) begin
      n = $urandom_range(30, 1);
      for (int k = 0; k < n; k++) word_buf[k] = 8'($urandom_range(255));
    end else begin
      slot = $urandom_range(pool_used - 1);
      n = pool_len[slot];
      for (int k = 0; k < n; k++) begin
        c = pool_bytes[slot][k];
        if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) &&
            $urandom_range(1) == 1) begin
          c = c ^ 8'h20;
        end else if ((c >= 8'h09 && c <= 8'h0d) || c == 8'h20) begin
          c = blank_char();
        end
        word_buf[k] = c;
      end
      // an extra space now and then; shifts positions, may push bytes out
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(n - 1);
        for (int k = n; k > pos; k--) word_buf[k] = word_buf[k-1];
        word_buf[pos] = 8'h20;
        n++;
      end
    end
    for (int k = 0; k < n; k++) put_word(word_buf[k], k == n - 1);
  endtask

  task automatic run_phase(input int words, input int idle, input int stall,
                           input int fresh, input bit hold);
    int stop_at;
    stop_at       = words_sent + words;
    send_idle_pct = idle;
    stall_pct     = stall;
    fresh_pct     = fresh;
    if (hold) hold_pending = 1'b1;
    while (words_sent < stop_at) send_ident();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_in_i   = '0;
    last_char_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening, no idling on either side
    put_word(8'h41, 1'b1);                       // upper-case letter folds, stored
    put_word(8'h61, 1'b1);                       // same key in lower case: duplicate
    put_word(8'h20, 1'b0);                       // blanks only: empty
    put_word(8'h09, 1'b0);
    put_word(8'h0d, 1'b1);
    put_word(8'h00, 1'b1);                       // lone zero: empty
    put_word(8'h80, 1'b0);                       // high bytes pass untouched
    put_word(8'hff, 1'b1);
    put_word(8'h5a, 1'b0);                       // zero stops the scan, key is "z"
    put_word(8'h00, 1'b0);
    put_word(8'h41, 1'b1);
    put_word(8'h5a, 1'b1);                       // "z" again: duplicate
    put_word(8'h40, 1'b0);                       // bytes just outside letter and
    put_word(8'h5b, 1'b0);                       // blank ranges are kept
    put_word(8'h60, 1'b0);
    put_word(8'h7b, 1'b0);
    put_word(8'h08, 1'b0);
    put_word(8'h0e, 1'b0);
    put_word(8'h1f, 1'b0);
    put_word(8'h21, 1'b1);

    // random phases against a partly filled table
    run_phase(300, 0, 0, 82, 1'b0);
    run_phase(250, 86, 0, 80, 1'b0);

    // top the table up with distinct two-byte keys, so the phases after
    // this one run against a full table (replays still hit as duplicates)
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < 256; i++) begin
      put_word(8'hc0 + 8'(i / 16), 1'b0);
      put_word(8'hc0 + 8'(i % 16), 1'b1);
    end

    run_phase(150, 0, 86, 65, 1'b0);
    run_phase(150, 26, 26, 60, 1'b0);
    run_phase(150, 0, 0, 60, 1'b1);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // settle time for any stray result word after the last lookup
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run covered %0d words: %0d stored, %0d duplicate, %0d empty, %0d table full",
             words_sent, n_stored, n_dup, n_empty, n_full);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
